/* rtl/aging_page_replacement_defines.svh */
// Assertion macros for the aging page replacement block.
// Used by the top level; no other dependencies.
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define APR_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("aging page replacement assertion failed");
// Next-cycle implication.
`define APR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("aging page replacement assertion failed");
`else
`define APR_ASSERT(lbl, clk, rstn, ante, cons)
`define APR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/apr_pkg.sv */
// Shared constants and codes for the aging page replacement block.
// No dependencies.
package apr_pkg;
  localparam int APR_FRAMES     = 64;
  localparam int APR_AGE_BITS   = 64;
  localparam int APR_PAGE_SHIFT = 12;
  localparam int ADDR_W         = 32;
  localparam int PICK_W         = 6;
  localparam int IDX_OUT_W      = 6;
  localparam int EVICT_W        = 20;
  localparam int LIMIT_W        = 8;
  localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RST = 8'd1;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_FILL   = 2'd1,
    OUT_EVICT  = 2'd2,
    OUT_RANDOM = 2'd3
  } outcome_t;
endpackage

/* rtl/apr_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module apr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/aging_page_replacement.sv */
// Top level of the aging page replacement block.
// Depends on apr_pkg, apr_ram and aging_page_replacement_defines.svh.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_address, in_random_pick              | start high, busy low
//  result  | out_outcome, out_frame_index,           | out_valid, one cycle,
//          | out_evicted_page                        | cannot be held off
//  config  | cfg_data (repeat_limit)                 | cfg_valid and cfg_ready
//
// Each word takes one sweep of the frame memory that reads, ages and writes
// back one frame a cycle, then a pick state that picks the frame and reads it,
// and an update state that writes it back; the registered result comes in the
// cycle after that. The single read port sets the rate; busy blocks new words.
// Reset is synchronous, active low; a valid bit per frame makes every frame
// read as empty with zero age after reset, so no clearing pass is needed.

`include "aging_page_replacement_defines.svh"

module aging_page_replacement
  import apr_pkg::*;
#(
  parameter int FRAMES     = APR_FRAMES,
  parameter int AGE_BITS   = APR_AGE_BITS,
  parameter int PAGE_SHIFT = APR_PAGE_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [PICK_W-1:0]    in_random_pick,
  output logic                 out_valid,
  output logic [1:0]           out_outcome,
  output logic [IDX_OUT_W-1:0] out_frame_index,
  output logic [EVICT_W-1:0]   out_evicted_page,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data
);
  localparam int IDX_W = $clog2(FRAMES);
  localparam int PG_W  = ADDR_W - PAGE_SHIFT;
  localparam int ENT_W = PG_W + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_TOP  = {1'b1, {(AGE_BITS-1){1'b0}}};
  localparam logic [AGE_BITS-1:0] AGE_ONES = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_PICK = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Random pick reduced modulo the frame count through a constant table.
  logic [IDX_W-1:0] pick_tab [2**PICK_W];
  for (genvar g = 0; g < 2**PICK_W; g++) begin : g_pick
    assign pick_tab[g] = IDX_W'(g % FRAMES);
  end

  // Per-item registers.
  logic [PG_W-1:0]     page_r, page_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;
  logic [IDX_W:0]      rd_cnt_r, rd_cnt_nxt;
  logic                proc_r, proc_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;
  logic                hit_f_r, hit_f_nxt, emp_f_r, emp_f_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt, emp_idx_r, emp_idx_nxt;
  logic [AGE_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]    victim_r, victim_nxt;
  logic [1:0]          outcome_r, outcome_nxt;

  // Block-wide state.
  logic [PG_W-1:0]     last_ev_r, last_ev_nxt;
  logic [LIMIT_W-1:0]  rcount_r, rcount_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [FRAMES-1:0]   valid_r, valid_nxt;
  logic                vld_q_r;

  // Result registers.
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_outcome_r, out_outcome_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic [EVICT_W-1:0]  out_ev_r, out_ev_nxt;

  // Frame memory: {page, age} per frame.
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENT_W-1:0]   wdata, rdata;
  logic [PG_W-1:0]    rd_page;
  logic [AGE_BITS-1:0] rd_age, aged;
  logic [LIMIT_W-1:0] rc_inc;

  apr_ram #(.WIDTH(ENT_W), .DEPTH(FRAMES)) u_frames (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // A frame never written reads as empty with zero age.
  assign rd_page = vld_q_r ? rdata[ENT_W-1:AGE_BITS] : '0;
  assign rd_age  = vld_q_r ? rdata[AGE_BITS-1:0] : '0;
  assign aged    = rd_age >> 1;
  assign rc_inc  = rcount_r + LIMIT_W'(1);

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_frame_index  = out_idx_r;
  assign out_evicted_page = out_ev_r;

  always_comb begin
    state_nxt    = state_r;
    page_nxt     = page_r;
    pick_nxt     = pick_r;
    rd_cnt_nxt   = rd_cnt_r;
    proc_nxt     = 1'b0;
    pidx_nxt     = pidx_r;
    hit_f_nxt    = hit_f_r;
    hit_idx_nxt  = hit_idx_r;
    emp_f_nxt    = emp_f_r;
    emp_idx_nxt  = emp_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    victim_nxt   = victim_r;
    outcome_nxt  = outcome_r;
    last_ev_nxt  = last_ev_r;
    rcount_nxt   = rcount_r;
    limit_nxt    = (cfg_valid && cfg_ready) ? cfg_data : limit_r;
    valid_nxt    = valid_r;
    out_valid_nxt   = 1'b0;
    out_outcome_nxt = out_outcome_r;
    out_idx_nxt     = out_idx_r;
    out_ev_nxt      = out_ev_r;
    we    = 1'b0;
    waddr = pidx_r;
    wdata = {rd_page, aged};
    raddr = rd_cnt_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt   = in_address[ADDR_W-1:PAGE_SHIFT];
          pick_nxt   = pick_tab[in_random_pick];
          rd_cnt_nxt = '0;
          hit_f_nxt  = 1'b0;
          emp_f_nxt  = 1'b0;
          best_nxt   = AGE_ONES;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the read of the next frame.
        if (rd_cnt_r < (IDX_W+1)'(FRAMES)) begin
          proc_nxt   = 1'b1;
          pidx_nxt   = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt = rd_cnt_r + (IDX_W+1)'(1);
        end
        // Age the frame read last cycle and track hit, empty and minimum.
        if (proc_r) begin
          we = 1'b1;
          if (!hit_f_r && rd_page == page_r) begin
            hit_f_nxt   = 1'b1;
            hit_idx_nxt = pidx_r;
          end
          if (!emp_f_r && rd_page == '0) begin
            emp_f_nxt   = 1'b1;
            emp_idx_nxt = pidx_r;
          end
          if (aged < best_r) begin
            best_nxt     = aged;
            best_idx_nxt = pidx_r;
          end
          if (pidx_r == IDX_W'(FRAMES-1)) begin
            state_nxt = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (hit_f_r) begin
          victim_nxt  = hit_idx_r;
          outcome_nxt = OUT_HIT;
        end else if (emp_f_r) begin
          victim_nxt  = emp_idx_r;
          outcome_nxt = OUT_FILL;
        end else begin
          rcount_nxt = (last_ev_r == page_r) ? rc_inc : '0;
          if (rcount_nxt == limit_r) begin
            rcount_nxt  = '0;
            victim_nxt  = pick_r;
            outcome_nxt = OUT_RANDOM;
          end else begin
            victim_nxt  = best_idx_r;
            outcome_nxt = OUT_EVICT;
          end
        end
        raddr     = victim_nxt;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        we    = 1'b1;
        waddr = victim_r;
        wdata = {page_r, rd_age | AGE_TOP};
        out_valid_nxt   = 1'b1;
        out_outcome_nxt = outcome_r;
        out_idx_nxt     = IDX_OUT_W'(victim_r);
        if (outcome_r == OUT_EVICT || outcome_r == OUT_RANDOM) begin
          out_ev_nxt  = EVICT_W'(rd_page);
          last_ev_nxt = rd_page;
        end else begin
          out_ev_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      proc_r      <= 1'b0;
      rd_cnt_r    <= '0;
      last_ev_r   <= '0;
      rcount_r    <= '0;
      limit_r     <= REPEAT_LIMIT_RST;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_r      <= proc_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      last_ev_r   <= last_ev_nxt;
      rcount_r    <= rcount_nxt;
      limit_r     <= limit_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r        <= page_nxt;
    pick_r        <= pick_nxt;
    pidx_r        <= pidx_nxt;
    hit_f_r       <= hit_f_nxt;
    hit_idx_r     <= hit_idx_nxt;
    emp_f_r       <= emp_f_nxt;
    emp_idx_r     <= emp_idx_nxt;
    best_r        <= best_nxt;
    best_idx_r    <= best_idx_nxt;
    victim_r      <= victim_nxt;
    outcome_r     <= outcome_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_idx_r     <= out_idx_nxt;
    out_ev_r      <= out_ev_nxt;
    vld_q_r       <= valid_r[raddr];
  end

  // A result only follows the write-back cycle.
  `APR_ASSERT_NEXT(a_res_after_upd, clk, rst_n, state_r == ST_UPD, out_valid)
  // An accepted word always makes the block busy.
  `APR_ASSERT_NEXT(a_busy_on_start, clk, rst_n, start && !busy, busy)
  // Hits and fills never report an evicted page.
  `APR_ASSERT(a_no_evict_on_hit, clk, rst_n,
    out_valid && (out_outcome == OUT_HIT || out_outcome == OUT_FILL),
    out_evicted_page == '0)
  // The sweep counter never runs past the frame count.
  `APR_ASSERT(a_scan_bound, clk, rst_n, state_r == ST_SCAN,
    rd_cnt_r <= (IDX_W+1)'(FRAMES))
endmodule

/* tb/aging_page_replacement_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the aging page replacement block.
// Depends on apr_pkg and the aging_page_replacement top level.
// A directed table runs first, then random accesses checked against a local model.

module aging_page_replacement_tb;
  import apr_pkg::*;

  localparam int NFRAMES   = APR_FRAMES;
  localparam int SHIFT     = APR_PAGE_SHIFT;
  localparam int N_RANDOM  = 1168;
  localparam int CYCLE_CAP = 2000000;

  // One expected result word.
  typedef struct packed {
    logic [1:0]           outcome;
    logic [IDX_OUT_W-1:0] frame;
    logic [EVICT_W-1:0]   evicted;
  } access_result_t;

  // One row of the directed table. When has_check is set the typed-in
  // result is also compared against the model's prediction.
  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [PICK_W-1:0] pick;
    bit                has_check;
    access_result_t    typed;
  } access_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ADDR_W-1:0]    in_address;
  logic [PICK_W-1:0]    in_random_pick;
  logic                 out_valid;
  logic [1:0]           out_outcome;
  logic [IDX_OUT_W-1:0] out_frame_index;
  logic [EVICT_W-1:0]   out_evicted_page;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;

  aging_page_replacement dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_address       (in_address),
    .in_random_pick   (in_random_pick),
    .out_valid        (out_valid),
    .out_outcome      (out_outcome),
    .out_frame_index  (out_frame_index),
    .out_evicted_page (out_evicted_page),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Local copy of the block's state, kept in step with each accepted word.
  logic [EVICT_W-1:0]        pages_m [NFRAMES];
  logic [APR_AGE_BITS-1:0]   ages_m  [NFRAMES];
  logic [EVICT_W-1:0]        last_evicted_m;
  logic [LIMIT_W-1:0]        repeat_count_m;
  logic [LIMIT_W-1:0]        repeat_limit_m;

  access_result_t pending_results[$];
  int errors;
  int cycles;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Applies one access to the local state and returns the result it causes.
  function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr,
                                                    input logic [PICK_W-1:0] pick);
    logic [EVICT_W-1:0]      page;
    logic [APR_AGE_BITS-1:0] best;
    int                      victim;
    access_result_t          r;
    page = addr[ADDR_W-1:SHIFT];
    for (int i = 0; i < NFRAMES; i++) ages_m[i] = ages_m[i] >> 1;
    // A hit includes page zero landing on an empty frame.
    for (int i = 0; i < NFRAMES; i++) begin
      if (pages_m[i] == page) begin
        ages_m[i][APR_AGE_BITS-1] = 1'b1;
        r.outcome = OUT_HIT;
        r.frame   = IDX_OUT_W'(i);
        r.evicted = '0;
        return r;
      end
    end
    for (int i = 0; i < NFRAMES; i++) begin
      if (pages_m[i] == '0) begin
        pages_m[i] = page;
        ages_m[i][APR_AGE_BITS-1] = 1'b1;
        r.outcome = OUT_FILL;
        r.frame   = IDX_OUT_W'(i);
        r.evicted = '0;
        return r;
      end
    end
    if (last_evicted_m == page) repeat_count_m = repeat_count_m + LIMIT_W'(1);
    else repeat_count_m = '0;
    if (repeat_count_m == repeat_limit_m) begin
      repeat_count_m = '0;
      victim = int'(pick) % NFRAMES;
      r.outcome = OUT_RANDOM;
    end else begin
      // Strict less-than keeps the lowest frame on an age tie.
      best = '1;
      victim = 0;
      for (int i = 0; i < NFRAMES; i++) begin
        if (ages_m[i] < best) begin
          best = ages_m[i];
          victim = i;
        end
      end
      r.outcome = OUT_EVICT;
    end
    r.evicted = pages_m[victim];
    r.frame   = IDX_OUT_W'(victim);
    last_evicted_m = pages_m[victim];
    pages_m[victim] = page;
    ages_m[victim][APR_AGE_BITS-1] = 1'b1;
    return r;
  endfunction

  // Result side: the block cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_outcome != want.outcome)
          report_mismatch("outcome", 32'(out_outcome), 32'(want.outcome));
        if (out_frame_index != want.frame)
          report_mismatch("frame_index", 32'(out_frame_index), 32'(want.frame));
        if (out_evicted_page != want.evicted)
          report_mismatch("evicted_page", 32'(out_evicted_page), 32'(want.evicted));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("aging_page_replacement_tb: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, sometimes a long one, sometimes none.
  task automatic idle_gap();
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) n = 0;
    else if (roll < 92) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 150);
    repeat (n) @(negedge clk);
  endtask

  // Presents one word and waits for it to be taken. The prediction is
  // pushed at the accepting edge so the result side always finds it.
  // Start drops at a falling edge before the task returns, so the next
  // word is never raised in the same time step.
  task automatic send_access(input logic [ADDR_W-1:0] addr,
                             input logic [PICK_W-1:0] pick,
                             output access_result_t predicted);
    in_address     <= addr;
    in_random_pick <= pick;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_access(addr, pick);
    pending_results.push_back(predicted);
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every expected word has come, then lets the block settle.
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    repeat_limit_m = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Address whose page lies in a pool; small pools force evictions and repeats.
  function automatic logic [ADDR_W-1:0] pool_address(input int pool);
    logic [EVICT_W-1:0] page;
    page = EVICT_W'($urandom_range(1, pool));
    return {page, 12'($urandom)};
  endfunction

  access_row_t table_rows[$];

  initial begin
    access_result_t got;
    logic [ADDR_W-1:0] a;
    int limits[4];
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_address = '0;
    in_random_pick = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < NFRAMES; i++) begin
      pages_m[i] = '0;
      ages_m[i]  = '0;
    end
    last_evicted_m = '0;
    repeat_count_m = '0;
    repeat_limit_m = REPEAT_LIMIT_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. After reset, page zero hits the first empty frame,
    // the top page fills frame 0, and an access to it again hits there.
    table_rows.push_back('{32'h0000_0fff, 6'd0,  1'b1, '{OUT_HIT,  6'd0, 20'd0}});
    table_rows.push_back('{32'hffff_ffff, 6'd63, 1'b1, '{OUT_FILL, 6'd0, 20'd0}});
    table_rows.push_back('{32'hffff_f000, 6'd0,  1'b1, '{OUT_HIT,  6'd0, 20'd0}});
    table_rows.push_back('{32'h0000_1000, 6'd21, 1'b1, '{OUT_FILL, 6'd1, 20'd0}});
    foreach (table_rows[k]) begin
      send_access(table_rows[k].address, table_rows[k].pick, got);
      if (table_rows[k].has_check && got != table_rows[k].typed)
        report_mismatch("table row", 32'(got), 32'(table_rows[k].typed));
    end
    // Fill the rest of the frames, then evict by age and re-request the
    // evicted page so that the random path fires with the reset limit.
    for (int i = 2; i < NFRAMES; i++)
      send_access(ADDR_W'(32'h0010_0000 + (i << SHIFT)), PICK_W'(i), got);
    send_access(32'h0abc_d000, 6'd42, got);
    send_access({last_evicted_m, 12'h123}, 6'd63, got);
    send_access({last_evicted_m, 12'h000}, 6'd0, got);
    send_access(32'h0000_0000, 6'd17, got);
    drain();

    // Zero limit: random victim only after the counter wraps.
    write_limit(8'd0);
    for (int i = 0; i < 270; i++) begin
      send_access({last_evicted_m, 12'($urandom)}, 6'($urandom), got);
      if (i % 40 == 0) idle_gap();
    end
    drain();

    limits = '{255, 2, 1, 3};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(LIMIT_W'(limits[ph]));
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: a = {last_evicted_m, 12'($urandom)};
          3:       a = $urandom;
          4:       a = {20'($urandom_range(0, 3)), 12'($urandom)};
          default: a = pool_address(ph == 0 ? 70 : 100);
        endcase
        send_access(a, 6'($urandom), got);
        idle_gap();
      end
      drain();
    end
    write_limit(8'($urandom_range(1, 255)));
    for (int n = 0; n < 40; n++) begin
      send_access(pool_address(80), 6'($urandom), got);
      idle_gap();
    end
    drain();

    if (errors == 0) begin
      $display("aging_page_replacement_tb: PASS");
    end else begin
      $display("aging_page_replacement_tb: FAIL");
    end
    $finish;
  end
endmodule
